### src/pdi_pkg.sv
// Package for the point distance block: the shared stage control struct
// and the fixed width of the distance result. It depends on nothing.
package pdi_pkg;

    // Width of the distance result field
    localparam int DIST_WIDTH = 32;

    // Per-stage control: incoming valid and the load strobe of the stage
    typedef struct packed {
        logic valid;
        logic load;
    } stage_ctl_t;

endpackage

### src/point_distance_isqrt_top.sv
// Point distance block: floor of the Euclidean distance between two points.
// Uses pdi_pkg, pdi_span, pdi_square and pdi_root_step.
//
// Usage:
//   Query channel (query_valid / query_stall) carries from_x, from_y, to_x,
//   to_y as COORD_WIDTH-bit signed coordinates. Result channel
//   (result_valid / result_stall) carries the 32-bit distance. A transaction
//   completes on a rising edge with valid high and stall low.
//   Pipeline: absolute differences, squares, sum, then one square-root digit
//   per stage (COORD_WIDTH + 1 digit stages). That is COORD_WIDTH + 4 stages
//   in all. Throughput is one query per cycle while result_stall is low,
//   set by the single-digit stages of the root pipeline. Each stage loads
//   when it is empty or the stage after it loads, so bubbles close up and
//   queries keep entering while a result waits under result_stall;
//   query_stall rises only once every stage holds a transaction. Nothing is
//   lost or repeated across a stall.
//   Reset (rst_n low, asynchronous) empties every stage; no state is kept
//   between queries.
module point_distance_isqrt_top #(
    parameter int COORD_WIDTH = 31
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   query_valid,
    output logic                                   query_stall,
    input  logic signed [COORD_WIDTH-1:0]          from_x,
    input  logic signed [COORD_WIDTH-1:0]          from_y,
    input  logic signed [COORD_WIDTH-1:0]          to_x,
    input  logic signed [COORD_WIDTH-1:0]          to_y,
    output logic                                   result_valid,
    input  logic                                   result_stall,
    output logic        [pdi_pkg::DIST_WIDTH-1:0]  distance
);

    localparam int CW     = COORD_WIDTH;
    localparam int PW     = 2 * COORD_WIDTH;
    localparam int SW     = 2 * COORD_WIDTH + 1;
    localparam int NDIG   = COORD_WIDTH + 1;
    localparam int NSTAGE = NDIG + 3;

    // Stage indexes
    localparam int ST_SPAN   = 0;
    localparam int ST_SQUARE = 1;
    localparam int ST_SUM    = 2;
    localparam int ST_ROOT   = 3;

    logic [NSTAGE-1:0] stage_valid;
    logic [NSTAGE-1:0] stage_load;

    logic [CW-1:0] dx;
    logic [CW-1:0] dy;
    logic [PW-1:0] sq_x;
    logic [PW-1:0] sq_y;

    logic          sum_valid_reg;
    logic [SW-1:0] sum_reg;
    logic [SW-1:0] sum_next;

    logic [SW-1:0] rem_s  [0:NDIG];
    logic [SW-1:0] root_s [0:NDIG];

    pdi_pkg::stage_ctl_t span_ctl;
    pdi_pkg::stage_ctl_t square_ctl;

    // Load chain: a stage loads when empty or when its successor loads
    assign stage_load[NSTAGE-1] = !stage_valid[NSTAGE-1] || !result_stall;
    genvar gi;
    generate
        for (gi = 0; gi < NSTAGE - 1; gi++)
        begin : g_load
            assign stage_load[gi] = !stage_valid[gi] || stage_load[gi+1];
        end
    endgenerate

    assign query_stall = !stage_load[ST_SPAN];

    // Absolute differences
    assign span_ctl.valid = query_valid;
    assign span_ctl.load  = stage_load[ST_SPAN];

    pdi_span #(
        .COORD_WIDTH(CW)
    ) u_span (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (span_ctl),
        .from_x (from_x),
        .from_y (from_y),
        .to_x   (to_x),
        .to_y   (to_y),
        .valid  (stage_valid[ST_SPAN]),
        .dx     (dx),
        .dy     (dy)
    );

    // Squares
    assign square_ctl.valid = stage_valid[ST_SPAN];
    assign square_ctl.load  = stage_load[ST_SQUARE];

    pdi_square #(
        .COORD_WIDTH(CW)
    ) u_square (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (square_ctl),
        .dx    (dx),
        .dy    (dy),
        .valid (stage_valid[ST_SQUARE]),
        .sq_x  (sq_x),
        .sq_y  (sq_y)
    );

    // Sum of squares, one bit wider than a square
    assign sum_next = {1'b0, sq_x} + {1'b0, sq_y};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg <= 1'b0;
        end
        else if (stage_load[ST_SUM])
        begin
            sum_valid_reg <= stage_valid[ST_SQUARE];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_load[ST_SUM])
        begin
            sum_reg <= sum_next;
        end
    end

    assign stage_valid[ST_SUM] = sum_valid_reg;
    assign rem_s[0]            = sum_reg;
    assign root_s[0]           = '0;

    // Root digits, most significant pair first
    generate
        for (gi = 0; gi < NDIG; gi++)
        begin : g_root
            pdi_pkg::stage_ctl_t step_ctl;

            assign step_ctl.valid = stage_valid[ST_ROOT+gi-1];
            assign step_ctl.load  = stage_load[ST_ROOT+gi];

            pdi_root_step #(
                .SUM_WIDTH (SW),
                .STEP      (NDIG - 1 - gi)
            ) u_step (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (step_ctl),
                .rem_in   (rem_s[gi]),
                .root_in  (root_s[gi]),
                .valid    (stage_valid[ST_ROOT+gi]),
                .rem_out  (rem_s[gi+1]),
                .root_out (root_s[gi+1])
            );
        end
    endgenerate

    // Result
    assign result_valid = stage_valid[NSTAGE-1];
    assign distance     = pdi_pkg::DIST_WIDTH'(root_s[NDIG]);

endmodule

### src/pdi_span.sv
// Front stage: absolute x and y differences between the two points.
// Depends on pdi_pkg for the stage control struct.
module pdi_span #(
    parameter int COORD_WIDTH = 31
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pdi_pkg::stage_ctl_t           ctl,
    input  logic signed [COORD_WIDTH-1:0] from_x,
    input  logic signed [COORD_WIDTH-1:0] from_y,
    input  logic signed [COORD_WIDTH-1:0] to_x,
    input  logic signed [COORD_WIDTH-1:0] to_y,
    output logic                          valid,
    output logic        [COORD_WIDTH-1:0] dx,
    output logic        [COORD_WIDTH-1:0] dy
);

    localparam int CW = COORD_WIDTH;

    logic          valid_reg;
    logic [CW-1:0] dx_reg;
    logic [CW-1:0] dy_reg;
    logic [CW-1:0] dx_next;
    logic [CW-1:0] dy_next;
    logic [CW:0]   fwd_x;
    logic [CW:0]   rev_x;
    logic [CW:0]   fwd_y;
    logic [CW:0]   rev_y;

    // Both subtraction orders in parallel; the sign of one picks the magnitude
    always_comb
    begin
        fwd_x = {to_x[CW-1], to_x} - {from_x[CW-1], from_x};
        rev_x = {from_x[CW-1], from_x} - {to_x[CW-1], to_x};
        fwd_y = {to_y[CW-1], to_y} - {from_y[CW-1], from_y};
        rev_y = {from_y[CW-1], from_y} - {to_y[CW-1], to_y};
        dx_next = fwd_x[CW] ? rev_x[CW-1:0] : fwd_x[CW-1:0];
        dy_next = fwd_y[CW] ? rev_y[CW-1:0] : fwd_y[CW-1:0];
    end

    // Stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.load)
        begin
            valid_reg <= ctl.valid;
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
    end

    assign valid = valid_reg;
    assign dx    = dx_reg;
    assign dy    = dy_reg;

endmodule

### src/pdi_square.sv
// Squaring stage: one multiplier per axis, products registered.
// Depends on pdi_pkg for the stage control struct.
module pdi_square #(
    parameter int COORD_WIDTH = 31
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pdi_pkg::stage_ctl_t           ctl,
    input  logic [COORD_WIDTH-1:0]        dx,
    input  logic [COORD_WIDTH-1:0]        dy,
    output logic                          valid,
    output logic [2*COORD_WIDTH-1:0]      sq_x,
    output logic [2*COORD_WIDTH-1:0]      sq_y
);

    localparam int CW = COORD_WIDTH;
    localparam int PW = 2 * COORD_WIDTH;

    logic          valid_reg;
    logic [PW-1:0] sq_x_reg;
    logic [PW-1:0] sq_y_reg;
    logic [PW-1:0] sq_x_next;
    logic [PW-1:0] sq_y_next;

    // Exact squares of the magnitudes
    always_comb
    begin
        sq_x_next = {{CW{1'b0}}, dx} * {{CW{1'b0}}, dx};
        sq_y_next = {{CW{1'b0}}, dy} * {{CW{1'b0}}, dy};
    end

    // Stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.load)
        begin
            valid_reg <= ctl.valid;
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            sq_x_reg <= sq_x_next;
            sq_y_reg <= sq_y_next;
        end
    end

    assign valid = valid_reg;
    assign sq_x  = sq_x_reg;
    assign sq_y  = sq_y_reg;

endmodule

### src/pdi_root_step.sv
// One digit of the bit-pair integer square root, as a registered stage.
// Depends on pdi_pkg for the stage control struct.
module pdi_root_step #(
    parameter int SUM_WIDTH = 63,
    parameter int STEP      = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pdi_pkg::stage_ctl_t  ctl,
    input  logic [SUM_WIDTH-1:0] rem_in,
    input  logic [SUM_WIDTH-1:0] root_in,
    output logic                 valid,
    output logic [SUM_WIDTH-1:0] rem_out,
    output logic [SUM_WIDTH-1:0] root_out
);

    localparam int SW = SUM_WIDTH;
    localparam logic [SW-1:0] PROBE = SW'(1) << (2 * STEP);

    logic          valid_reg;
    logic [SW-1:0] rem_reg;
    logic [SW-1:0] root_reg;
    logic [SW-1:0] rem_next;
    logic [SW-1:0] root_next;
    logic [SW-1:0] trial;

    // Trial subtract of root + probe; keep the remainder if it would go negative
    always_comb
    begin
        trial = root_in + PROBE;
        if (rem_in >= trial)
        begin
            rem_next  = rem_in - trial;
            root_next = (root_in >> 1) + PROBE;
        end
        else
        begin
            rem_next  = rem_in;
            root_next = root_in >> 1;
        end
    end

    // Stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.load)
        begin
            valid_reg <= ctl.valid;
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign valid    = valid_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;

endmodule

### verif/tb.sv
// Testbench for point_distance_isqrt_top: directed and random distance queries
// under varied sender gaps and result stalls, checked against a local predictor.
// Depends on src/pdi_pkg.sv and the point_distance_isqrt_top RTL; nothing else.
module tb;

    localparam int CW = 31;
    localparam int PIPE_DEPTH = CW + 4;
    localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};

    // One query as seen at the input, with the distance it should give
    typedef struct {
        logic signed [CW-1:0]            fx;
        logic signed [CW-1:0]            fy;
        logic signed [CW-1:0]            tx;
        logic signed [CW-1:0]            ty;
        logic [pdi_pkg::DIST_WIDTH-1:0]  exp_dist;
    } query_rec_t;

    // Holds the distances still owed by the block, oldest first
    class distance_checker;
        query_rec_t owed_distances[$];
        int         faults;

        function new();
            faults = 0;
        endfunction

        // Floor of sqrt(dx^2 + dy^2), found one root bit at a time
        function automatic logic [pdi_pkg::DIST_WIDTH-1:0] floor_distance(
            logic signed [CW-1:0] fx, logic signed [CW-1:0] fy,
            logic signed [CW-1:0] tx, logic signed [CW-1:0] ty);
            longint     ddx;
            longint     ddy;
            logic [63:0] ax;
            logic [63:0] ay;
            logic [63:0] radicand;
            logic [63:0] trial;
            logic [63:0] root;
            ddx = longint'(tx) - longint'(fx);
            ddy = longint'(ty) - longint'(fy);
            ax = (ddx < 0) ? 64'(-ddx) : 64'(ddx);
            ay = (ddy < 0) ? 64'(-ddy) : 64'(ddy);
            radicand = ax * ax + ay * ay;
            root = 64'd0;
            for (int b = 31; b >= 0; b--)
            begin
                trial = root | (64'd1 << b);
                if (trial * trial <= radicand)
                    root = trial;
            end
            return root[pdi_pkg::DIST_WIDTH-1:0];
        endfunction

        function void note_query(logic signed [CW-1:0] fx, logic signed [CW-1:0] fy,
                                 logic signed [CW-1:0] tx, logic signed [CW-1:0] ty);
            query_rec_t rec;
            rec.fx = fx;
            rec.fy = fy;
            rec.tx = tx;
            rec.ty = ty;
            rec.exp_dist = floor_distance(fx, fy, tx, ty);
            owed_distances.push_back(rec);
        endfunction

        function void check_distance(logic [pdi_pkg::DIST_WIDTH-1:0] actual);
            query_rec_t rec;
            if (owed_distances.size() == 0)
            begin
                faults++;
                if (faults <= 10)
                    $display("unexpected distance %0d with no query outstanding", actual);
                return;
            end
            rec = owed_distances.pop_front();
            if (actual !== rec.exp_dist)
            begin
                faults++;
                if (faults <= 10)
                    $display("distance mismatch (%0d,%0d)->(%0d,%0d): expected %0d, got %0d",
                             rec.fx, rec.fy, rec.tx, rec.ty, rec.exp_dist, actual);
            end
        endfunction

        function int pending();
            return owed_distances.size();
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n = 1'b0;
    logic                           query_valid = 1'b0;
    logic                           query_stall;
    logic signed [CW-1:0]           from_x = '0;
    logic signed [CW-1:0]           from_y = '0;
    logic signed [CW-1:0]           to_x = '0;
    logic signed [CW-1:0]           to_y = '0;
    logic                           result_valid;
    logic                           result_stall = 1'b0;
    logic [pdi_pkg::DIST_WIDTH-1:0] distance;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    distance_checker board = new();

    point_distance_isqrt_top #(
        .COORD_WIDTH (CW)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .query_valid  (query_valid),
        .query_stall  (query_stall),
        .from_x       (from_x),
        .from_y       (from_y),
        .to_x         (to_x),
        .to_y         (to_y),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .distance     (distance)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("status: fail");
        $finish;
    end

    // Result-side back-pressure, independent of everything else
    always @(posedge clk)
    begin
        result_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Monitor both channels; values read here are those before the edge
    always @(posedge clk)
    begin
        if (rst_n && query_valid && !query_stall)
            board.note_query(from_x, from_y, to_x, to_y);
        if (rst_n && result_valid && !result_stall)
            board.check_distance(distance);
    end

    // Present one query, with a random gap first, and hold it until taken
    task automatic send_query(input logic signed [CW-1:0] fx, input logic signed [CW-1:0] fy,
                              input logic signed [CW-1:0] tx, input logic signed [CW-1:0] ty);
        while ($urandom_range(99) < send_idle_pct)
        begin
            query_valid <= 1'b0;
            @(posedge clk);
        end
        query_valid <= 1'b1;
        from_x <= fx;
        from_y <= fy;
        to_x <= tx;
        to_y <= ty;
        @(posedge clk);
        while (query_stall)
            @(posedge clk);
    endtask

    // A coordinate biased towards the interesting values
    function automatic logic signed [CW-1:0] edge_coord();
        case ($urandom_range(5))
            0: return COORD_MIN;
            1: return COORD_MAX;
            2: return '1;
            3: return '0;
            4: return CW'(1);
            default: return CW'($urandom);
        endcase
    endfunction

    // One random query drawn from several shapes
    task automatic send_random_query();
        logic signed [CW-1:0] fx;
        logic signed [CW-1:0] fy;
        logic signed [CW-1:0] tx;
        logic signed [CW-1:0] ty;
        fx = CW'($urandom);
        fy = CW'($urandom);
        case ($urandom_range(3))
            // anywhere to anywhere
            0:
            begin
                tx = CW'($urandom);
                ty = CW'($urandom);
            end
            // nearby points, small differences
            1:
            begin
                tx = fx + CW'(int'($urandom_range(2000)) - 1000);
                ty = fy + CW'(int'($urandom_range(2000)) - 1000);
            end
            // corners, zero and unit values
            2:
            begin
                fx = edge_coord();
                fy = edge_coord();
                tx = edge_coord();
                ty = edge_coord();
            end
            // movement along one axis only
            default:
            begin
                tx = CW'($urandom);
                ty = fy;
            end
        endcase
        send_query(fx, fy, tx, ty);
    endtask

    // Stimulus and end of run
    initial
    begin
        int send_pcts[4];
        int stall_pcts[4];
        send_pcts = '{0, 74, 0, 32};
        stall_pcts = '{0, 0, 74, 32};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed queries
        send_query('0, '0, '0, '0);
        send_query(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        send_query(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
        send_query(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
        send_query(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN);
        send_query(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
        send_query(COORD_MIN, '0, COORD_MAX, '0);
        send_query('0, COORD_MAX, '0, COORD_MIN);
        send_query('0, '0, '0, COORD_MAX);
        send_query('0, '0, COORD_MIN, '0);
        send_query('0, '0, CW'(3), CW'(4));
        send_query('0, '0, -CW'(3), -CW'(4));
        send_query('1, '0, '0, '0);
        send_query('0, '0, CW'(3), CW'(3));
        send_query('0, '0, CW'(1), CW'(1));
        send_query(CW'(5), CW'(5), CW'(5), CW'(5));
        send_query('1, '1, CW'(1), CW'(1));
        send_query(CW'(100), -CW'(200), -CW'(500), CW'(700));
        send_query(CW'(32'h5555_5555), CW'(32'h2AAA_AAAA),
                   CW'(32'h2AAA_AAAA), CW'(32'h5555_5555));
        send_query('0, '0, CW'(65535), CW'(1));

        // Random queries across the idling phases, twice round
        for (int p = 0; p < 8; p++)
        begin
            send_idle_pct = send_pcts[p % 4];
            recv_stall_pct = stall_pcts[p % 4];
            repeat (190) send_random_query();
        end
        query_valid <= 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;

        // Drain, then give the pipeline time to show anything spurious
        while (board.pending() != 0)
            @(posedge clk);
        repeat (2 * PIPE_DEPTH) @(posedge clk);

        if (board.faults == 0 && board.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
